>>> src/alpha_word_tokenizer_unit_assert.svh
// Assertion macros shared by the word tokenizer checker.
`ifndef ALPHA_WORD_TOKENIZER_UNIT_ASSERT_SVH
`define ALPHA_WORD_TOKENIZER_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define AWT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer check failed: same-cycle rule");

// Next-cycle implication, checked at every clock edge outside reset.
`define AWT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer check failed: next-cycle rule");

`endif

>>> src/awt_pkg.sv
// Shared types and constants of the alphabetic word tokenizer.
package awt_pkg;

  localparam int BYTE_W   = 8;
  localparam int LETTER_W = 5;
  localparam int CHAR_W   = 7;
  localparam int MINLEN_W = 6;

  localparam logic [BYTE_W-1:0]   UPPER_A = 8'd65;
  localparam logic [BYTE_W-1:0]   UPPER_Z = 8'd90;
  localparam logic [BYTE_W-1:0]   LOWER_A = 8'd97;
  localparam logic [BYTE_W-1:0]   LOWER_Z = 8'd122;
  localparam logic [CHAR_W-1:0]   CHAR_A  = 7'd97;
  localparam logic [MINLEN_W-1:0] MIN_LEN_RESET = 6'd3;

  // Letter write from the front end into the word buffer.
  typedef struct packed {
    logic                en;
    logic [LETTER_W-1:0] letter;
  } letter_wr_t;

  // Per-word control carried through the descriptor queue.
  typedef struct packed {
    logic bank;
    logic trunc;
  } word_tag_t;

endpackage

>>> src/awt_front.sv
// Front end: accepts bytes, classifies letters, builds words and queues them.
module awt_front #(
  parameter int MAX_WORD_LEN = 32,
  parameter int IDX_W = $clog2(MAX_WORD_LEN),
  parameter int LEN_W = $clog2(MAX_WORD_LEN + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [awt_pkg::BYTE_W-1:0]    text_byte,
  input  logic                          end_of_text,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [awt_pkg::MINLEN_W-1:0]  cfg_data,
  input  logic                          q_full,
  output logic                          push,
  output awt_pkg::word_tag_t            push_tag,
  output logic [LEN_W-1:0]              push_len,
  output awt_pkg::letter_wr_t           wr,
  output logic [IDX_W:0]                wr_addr
);
  import awt_pkg::*;

  localparam int CMP_W = (LEN_W > MINLEN_W) ? LEN_W : MINLEN_W;

  logic [LEN_W-1:0]    count;
  logic                overflowed;
  logic                bank;
  logic [MINLEN_W-1:0] min_len;

  logic                is_upper;
  logic                is_lower;
  logic                is_letter;
  logic                accept;
  logic                room;
  logic                flush;
  logic                keep;
  logic [LEN_W-1:0]    count_next;
  logic                overflowed_next;
  logic [LETTER_W-1:0] letter_idx;

  // The front stalls whenever both word banks are claimed by queued words.
  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  // Classify the byte and work out the word state after it.
  always_comb begin
    is_upper   = text_byte inside {[UPPER_A:UPPER_Z]};
    is_lower   = text_byte inside {[LOWER_A:LOWER_Z]};
    is_letter  = is_upper || is_lower;
    letter_idx = is_upper ? LETTER_W'(text_byte - UPPER_A) : LETTER_W'(text_byte - LOWER_A);
    room       = count < LEN_W'(MAX_WORD_LEN);
    count_next = (is_letter && room) ? count + LEN_W'(1) : count;
    overflowed_next = overflowed || (is_letter && !room);
    flush      = !is_letter || end_of_text;
    keep       = (count_next != '0) && (CMP_W'(count_next) >= CMP_W'(min_len));
  end

  // Buffer write and word hand-off to the back end.
  always_comb begin
    wr.en          = accept && is_letter && room;
    wr.letter      = letter_idx;
    wr_addr        = {bank, count[IDX_W-1:0]};
    push           = accept && flush && keep;
    push_tag.bank  = bank;
    push_tag.trunc = overflowed_next;
    push_len       = count_next;
  end

  // Word state, bank select and the minimum length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      overflowed <= 1'b0;
      bank       <= 1'b0;
      min_len    <= MIN_LEN_RESET;
    end else begin
      if (accept) begin
        if (flush) begin
          count      <= '0;
          overflowed <= 1'b0;
        end else begin
          count      <= count_next;
          overflowed <= overflowed_next;
        end
      end
      if (push) begin
        bank <= !bank;
      end
      if (cfg_valid && cfg_ready) begin
        min_len <= cfg_data;
      end
    end
  end

endmodule

>>> src/awt_queue.sv
// Two-entry queue of finished word descriptors between front and back end.
module awt_queue #(
  parameter int LEN_W = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  awt_pkg::word_tag_t push_tag,
  input  logic [LEN_W-1:0]   push_len,
  input  logic               pop,
  output logic               q_full,
  output logic               head_valid,
  output awt_pkg::word_tag_t head_tag,
  output logic [LEN_W-1:0]   head_len
);
  import awt_pkg::*;

  word_tag_t        tag_q [2];
  logic [LEN_W-1:0] len_q [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign q_full     = fill == 2'd2;
  assign head_valid = fill != 2'd0;
  assign head_tag   = tag_q[rd_ptr];
  assign head_len   = len_q[rd_ptr];

  // Entry storage, no reset needed.
  always_ff @(posedge clk) begin
    if (push) begin
      tag_q[wr_ptr] <= push_tag;
      len_q[wr_ptr] <= push_len;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

>>> src/awt_back.sv
// Back end: holds the two-bank word buffer and streams queued words out.
module awt_back #(
  parameter int MAX_WORD_LEN = 32,
  parameter int IDX_W = $clog2(MAX_WORD_LEN),
  parameter int LEN_W = $clog2(MAX_WORD_LEN + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  awt_pkg::letter_wr_t          wr,
  input  logic [IDX_W:0]               wr_addr,
  input  logic                         head_valid,
  input  awt_pkg::word_tag_t           head_tag,
  input  logic [LEN_W-1:0]             head_len,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [awt_pkg::CHAR_W-1:0]   word_char,
  output logic                         last_of_word,
  output logic                         word_truncated
);
  import awt_pkg::*;

  localparam int DEPTH = 2 ** (IDX_W + 1);

  logic [LETTER_W-1:0] mem [DEPTH];
  logic [IDX_W-1:0]    pos;
  logic                load;
  logic                at_last;
  logic [IDX_W:0]      rd_addr;

  // A new character is read whenever the output register is free or draining.
  always_comb begin
    load    = head_valid && (!out_valid || !out_stall);
    at_last = (LEN_W'(pos) + LEN_W'(1)) == head_len;
    rd_addr = {head_tag.bank, pos};
    pop     = load && at_last;
  end

  // Word buffer write port from the front end.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.letter;
    end
  end

  // Registered read straight into the output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      word_char      <= CHAR_A + CHAR_W'(mem[rd_addr]);
      last_of_word   <= at_last;
      word_truncated <= head_tag.trunc;
    end
  end

  // Character position and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        pos       <= at_last ? '0 : pos + IDX_W'(1);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/alpha_word_tokenizer_unit.sv
// A word's ending byte queues its descriptor; its first character then leaves through the
// output register. Throughput: one byte per cycle in, one character per cycle out while
// out_stall is low; the input stalls only while two finished words hold both word buffer banks.
// Reset: rst is synchronous; it empties the word, the queue and the output, and sets the
// minimum word length to 3. The word buffer itself is not cleared.
module alpha_word_tokenizer_unit #(
  parameter int MAX_WORD_LEN = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [awt_pkg::BYTE_W-1:0]   text_byte,
  input  logic                         end_of_text,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [awt_pkg::MINLEN_W-1:0] cfg_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [awt_pkg::CHAR_W-1:0]   word_char,
  output logic                         last_of_word,
  output logic                         word_truncated
);
  import awt_pkg::*;

  localparam int IDX_W = $clog2(MAX_WORD_LEN);
  localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);

  logic             q_full;
  logic             push;
  word_tag_t        push_tag;
  logic [LEN_W-1:0] push_len;
  letter_wr_t       wr;
  logic [IDX_W:0]   wr_addr;
  logic             pop;
  logic             head_valid;
  word_tag_t        head_tag;
  logic [LEN_W-1:0] head_len;

  // Byte intake and word building.
  awt_front #(
    .MAX_WORD_LEN (MAX_WORD_LEN),
    .IDX_W        (IDX_W),
    .LEN_W        (LEN_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .push        (push),
    .push_tag    (push_tag),
    .push_len    (push_len),
    .wr          (wr),
    .wr_addr     (wr_addr)
  );

  // Finished words waiting for output.
  awt_queue #(
    .LEN_W (LEN_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_tag   (push_tag),
    .push_len   (push_len),
    .pop        (pop),
    .q_full     (q_full),
    .head_valid (head_valid),
    .head_tag   (head_tag),
    .head_len   (head_len)
  );

  // Character output.
  awt_back #(
    .MAX_WORD_LEN (MAX_WORD_LEN),
    .IDX_W        (IDX_W),
    .LEN_W        (LEN_W)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .wr             (wr),
    .wr_addr        (wr_addr),
    .head_valid     (head_valid),
    .head_tag       (head_tag),
    .head_len       (head_len),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .word_char      (word_char),
    .last_of_word   (last_of_word),
    .word_truncated (word_truncated)
  );

endmodule

>>> src/awt_checker.sv
// Port-level checks of the word tokenizer output stream, bound to the top level.
`include "alpha_word_tokenizer_unit_assert.svh"

module awt_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] word_char,
  input logic       last_of_word,
  input logic       word_truncated
);

  // Every emitted character is a lower-case letter.
  `AWT_ASSERT_NOW(a_char_lower, clk, rst, out_valid, (word_char >= 7'd97) && (word_char <= 7'd122))

  // A stalled item holds.
  `AWT_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && out_stall, out_valid && $stable(word_char) && $stable(last_of_word))

  // A word streams without gaps once it has started.
  `AWT_ASSERT_NEXT(a_word_no_gap, clk, rst, out_valid && !out_stall && !last_of_word, out_valid)

  // The truncation flag is the same on every character of a word.
  `AWT_ASSERT_NEXT(a_trunc_steady, clk, rst, out_valid && !out_stall && !last_of_word, word_truncated == $past(word_truncated))

endmodule

bind alpha_word_tokenizer_unit awt_checker u_awt_checker (.*);

>>> tb/awt_word_checker.sv
// Checker for the word tokenizer: predicts emitted characters and compares them.
`timescale 1ns / 100ps

module awt_word_checker #(
  parameter int WORD_CAP = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [awt_pkg::BYTE_W-1:0]   text_byte,
  input  logic                         end_of_text,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [awt_pkg::MINLEN_W-1:0] cfg_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [awt_pkg::CHAR_W-1:0]   word_char,
  input  logic                         last_of_word,
  input  logic                         word_truncated,
  output int                           fail_count,
  output int                           chars_waiting
);
  import awt_pkg::*;

  // One predicted output character.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              trunc;
  } word_char_t;

  // Predicted tokenizer state.
  logic [LETTER_W-1:0] letters [WORD_CAP];
  int                  held;
  logic                lost_letters;
  logic [MINLEN_W-1:0] min_len;
  word_char_t          char_q [$];
  word_char_t          wanted;

  initial begin
    fail_count    = 0;
    chars_waiting = 0;
  end

  // Prints one line for a mismatch and counts it.
  task automatic report_mismatch(input string msg);
    $display("tokenizer mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  // Ends the pending word and queues its characters if it is long enough.
  task automatic flush_word();
    word_char_t c;
    int         i;
    if (held > 0 && held >= min_len) begin
      for (i = 0; i < held; i++) begin
        c.ch    = CHAR_A + CHAR_W'(letters[i]);
        c.last  = (i + 1 == held);
        c.trunc = lost_letters;
        char_q  = {char_q, c};
      end
    end
    held         = 0;
    lost_letters = 1'b0;
  endtask

  // Applies one accepted text byte to the predicted state.
  task automatic take_byte(input logic [BYTE_W-1:0] b, input logic eot);
    logic is_upper;
    logic is_lower;
    is_upper = (b >= UPPER_A) && (b <= UPPER_Z);
    is_lower = (b >= LOWER_A) && (b <= LOWER_Z);
    if (is_upper || is_lower) begin
      if (held < WORD_CAP) begin
        letters[held] = is_upper ? LETTER_W'(b - UPPER_A) : LETTER_W'(b - LOWER_A);
        held++;
      end else begin
        lost_letters = 1'b1;
      end
      if (eot) begin
        flush_word();
      end
    end else begin
      flush_word();
    end
  endtask

  // Results are checked before the byte of the same edge is applied, since no
  // byte can produce a character on the edge it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      held         = 0;
      lost_letters = 1'b0;
      min_len      = MIN_LEN_RESET;
      char_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (char_q.size() == 0) begin
          report_mismatch($sformatf("unexpected character %0d", word_char));
        end else begin
          wanted = char_q.pop_front();
          if (word_char !== wanted.ch) begin
            report_mismatch($sformatf("word_char %0d, expected %0d", word_char, wanted.ch));
          end
          if (last_of_word !== wanted.last) begin
            report_mismatch($sformatf("last_of_word %b, expected %b",
                                      last_of_word, wanted.last));
          end
          if (word_truncated !== wanted.trunc) begin
            report_mismatch($sformatf("word_truncated %b, expected %b",
                                      word_truncated, wanted.trunc));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        min_len = cfg_data;
      end
      if (in_valid && !in_stall) begin
        take_byte(text_byte, end_of_text);
      end
    end
    chars_waiting <= char_q.size();
  end

endmodule

>>> tb/tb.sv
// Top of the word tokenizer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
  import awt_pkg::*;

  localparam int WORD_CAP    = 32;
  localparam int CYCLE_LIMIT = 100000;

  logic                clk            = 1'b0;
  logic                rst            = 1'b1;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic [BYTE_W-1:0]   text_byte      = '0;
  logic                end_of_text    = 1'b0;
  logic                cfg_valid      = 1'b0;
  logic                cfg_ready;
  logic [MINLEN_W-1:0] cfg_data       = '0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic [CHAR_W-1:0]   word_char;
  logic                last_of_word;
  logic                word_truncated;

  int   fail_count;
  int   chars_waiting;
  int   sent_items     = 0;
  int   cycle_count    = 0;
  int   hold_left      = 0;
  int   stall_left     = 0;
  logic long_hold_go   = 1'b0;
  logic long_hold_done = 1'b0;
  logic calm           = 1'b0;

  alpha_word_tokenizer_unit #(
    .MAX_WORD_LEN(WORD_CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .text_byte(text_byte),
    .end_of_text(end_of_text),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .word_char(word_char),
    .last_of_word(last_of_word),
    .word_truncated(word_truncated)
  );

  awt_word_checker #(
    .WORD_CAP(WORD_CAP)
  ) word_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .text_byte(text_byte),
    .end_of_text(end_of_text),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .word_char(word_char),
    .last_of_word(last_of_word),
    .word_truncated(word_truncated),
    .fail_count(fail_count),
    .chars_waiting(chars_waiting)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none when calm.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (long_hold_go && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_left      <= 120;
      out_stall      <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offers one text item, with an occasional idle burst ahead of it.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eot);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    text_byte   <= b;
    end_of_text <= eot;
    do @(posedge clk); while (in_stall);
    sent_items++;
  endtask

  // Sends a string, optionally marking its last byte as the end of text.
  task automatic send_text(input string s, input logic eot_last);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_byte(s[i], eot_last && (i == s.len() - 1));
    end
  endtask

  // Any byte outside both letter ranges.
  function automatic logic [BYTE_W-1:0] random_separator();
    logic [BYTE_W-1:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while ((b >= UPPER_A && b <= UPPER_Z) || (b >= LOWER_A && b <= LOWER_Z));
    return b;
  endfunction

  // Stops offering items and waits until every predicted character has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes the minimum word length once the block is idle.
  task automatic set_min_len(input logic [MINLEN_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random words of mixed case between random separators, with some noise bytes.
  // The phase closes with a flushing separator so no word spans a register write.
  task automatic random_phase(input int budget, input logic long_words);
    int   stop_at;
    int   len;
    int   i;
    logic end_on_letter;
    stop_at = sent_items + budget;
    while (sent_items < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      end else begin
        if (long_words || $urandom_range(0, 11) == 0) begin
          len = $urandom_range(28, 40);
        end else begin
          len = $urandom_range(1, 8);
        end
        end_on_letter = ($urandom_range(0, 7) == 0);
        for (i = 0; i < len; i++) begin
          send_byte(($urandom_range(0, 1) ? UPPER_A : LOWER_A) + 8'($urandom_range(0, 25)),
                    end_on_letter && (i == len - 1));
        end
        if (!end_on_letter) begin
          send_byte(random_separator(), $urandom_range(0, 9) == 0);
        end
      end
    end
    send_byte(random_separator(), 1'b1);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: letter range edges, neighboring separators, short words,
    // separators with no word, and end of text on a letter and on a separator.
    send_text("AzZa@", 1'b0);
    send_text("bc[", 1'b0);
    send_text("`{", 1'b0);
    send_byte(8'd255, 1'b0);
    send_byte(8'd128, 1'b0);
    send_text("QxY", 1'b1);
    send_byte(8'd0, 1'b1);

    // A minimum of zero still never emits an empty word.
    set_min_len(6'd0);
    send_text("k.", 1'b0);

    // A minimum above the buffer size suppresses every word.
    set_min_len(6'd63);
    send_text("abcdef", 1'b1);

    // Random phases over several minimum lengths.
    set_min_len(6'd1);
    random_phase(90, 1'b0);
    set_min_len(6'd32);
    random_phase(70, 1'b1);

    // The receiver holds off for a long stretch while text keeps coming.
    set_min_len(6'd2);
    long_hold_go <= 1'b1;
    random_phase(80, 1'b0);

    set_min_len(6'd33);
    random_phase(25, 1'b1);
    set_min_len(6'd5);
    random_phase(70, 1'b0);

    // Closing phase runs without idling on either side.
    set_min_len(MIN_LEN_RESET);
    calm <= 1'b1;
    random_phase(90, 1'b0);

    drain();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
